// ===== design/ile_pkg.sv =====
// ----------------------------------------------------------------------------
// ile_pkg: shared types and constants of the indexed list engine
// Holds the list depth, the word layouts of both channels, the opcode and
// status codes, and the command broadcast from the control to the cell row.
// ----------------------------------------------------------------------------
package ile_pkg;

    // list depth and derived widths
    localparam int CAPACITY = 16;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int POS_W    = 5;
    localparam int OPC_W    = 3;
    localparam int ENTRY_W  = 5;
    localparam int DATA_W   = 32;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [OPC_W-1:0] {
        OP_APPEND     = 3'd0,
        OP_INSERT     = 3'd1,
        OP_REMOVE     = 3'd2,
        OP_REMOVE_END = 3'd3,
        OP_READ       = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_BADPOS = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    // input word
    typedef struct packed {
        logic [OPC_W-1:0] opcode;
        logic [POS_W-1:0] position;
        data_t            item_value;
    } in_word_t;

    // result word
    typedef struct packed {
        data_t              read_value;
        status_t            status;
        logic [ENTRY_W-1:0] entry_count;
        logic               is_empty;
    } out_word_t;

    // command seen by every cell in the same cycle
    typedef struct packed {
        logic             shift_up;
        logic             shift_down;
        logic             write;
        logic [CMP_W-1:0] pos;
        data_t            value;
    } cell_cmd_t;

endpackage

// ===== design/ile_cell.sv =====
// ----------------------------------------------------------------------------
// ile_cell: one list slot
// Holds a single entry and, on a broadcast command, takes the value of its
// lower or upper neighbour, loads the new value, or keeps what it has.
// ----------------------------------------------------------------------------
module ile_cell
    import ile_pkg::*;
(
    input  logic             aclk,
    input  cell_cmd_t        cmd,
    input  logic [CMP_W-1:0] cell_idx,
    input  data_t            lower,
    input  data_t            upper,
    output data_t            value
);

    data_t value_reg;
    data_t value_next;

    // slot update: open a gap, fill it, or close one
    always_comb begin
        value_next = value_reg;
        if (cmd.shift_up && (cell_idx > cmd.pos)) begin
            value_next = lower;
        end else if (cmd.write && (cell_idx == cmd.pos)) begin
            value_next = cmd.value;
        end else if (cmd.shift_down && (cell_idx >= cmd.pos)) begin
            value_next = upper;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ===== design/ile_ctrl.sv =====
// ----------------------------------------------------------------------------
// ile_ctrl: opcode decode, entry count and result register
// Checks each word against the count, drives the cell row command, picks
// the read entry and holds the result word until the sink takes it.
// ----------------------------------------------------------------------------
module ile_ctrl
    import ile_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data,
    input  data_t     entries [CAPACITY],
    output cell_cmd_t cmd
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    out_word_t        m_data_reg;
    out_word_t        m_data_next;

    logic             accept;
    logic             full;
    logic             empty;
    logic [CMP_W-1:0] pos_ext;
    logic [CMP_W-1:0] count_ext;
    logic [CMP_W-1:0] count_dec;
    logic             rd_ok;
    status_t          status_c;
    cell_cmd_t        cmd_c;
    data_t            rd_value;

    // no word is taken while in reset
    assign s_ready   = aresetn && (!m_valid_reg || m_ready);
    assign accept    = s_valid && s_ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign pos_ext   = CMP_W'(s_data.position);
    assign count_ext = CMP_W'(count_reg);
    assign count_dec = count_ext - CMP_W'(1);

    // opcode decode against the current count
    always_comb begin
        cmd_c      = '0;
        cmd_c.value = s_data.item_value;
        status_c   = ST_OK;
        rd_ok      = 1'b0;
        count_next = count_reg;
        case (s_data.opcode)
            OP_APPEND: begin
                if (full) begin
                    status_c = ST_FULL;
                end else begin
                    cmd_c.write = 1'b1;
                    cmd_c.pos   = count_ext;
                    count_next  = count_reg + CNT_W'(1);
                end
            end
            OP_INSERT: begin
                if (full) begin
                    status_c = ST_FULL;
                end else if (pos_ext > count_ext) begin
                    status_c = ST_BADPOS;
                end else begin
                    cmd_c.shift_up = 1'b1;
                    cmd_c.write    = 1'b1;
                    cmd_c.pos      = pos_ext;
                    count_next     = count_reg + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (empty) begin
                    status_c = ST_EMPTY;
                end else if (pos_ext >= count_ext) begin
                    status_c = ST_BADPOS;
                end else begin
                    cmd_c.shift_down = 1'b1;
                    cmd_c.pos        = pos_ext;
                    count_next       = count_reg - CNT_W'(1);
                end
            end
            OP_REMOVE_END: begin
                if (empty) begin
                    status_c = ST_EMPTY;
                end else begin
                    cmd_c.pos  = count_dec;
                    count_next = count_reg - CNT_W'(1);
                end
            end
            OP_READ: begin
                if (empty) begin
                    status_c = ST_EMPTY;
                end else if (pos_ext >= count_ext) begin
                    status_c = ST_BADPOS;
                end else begin
                    rd_ok = 1'b1;
                end
            end
            default: begin
                status_c = ST_BADPOS;
            end
        endcase
    end

    // cells only move on an accepted word
    always_comb begin
        cmd            = cmd_c;
        cmd.shift_up   = cmd_c.shift_up && accept;
        cmd.shift_down = cmd_c.shift_down && accept;
        cmd.write      = cmd_c.write && accept;
    end

    // read selection over the cell row
    assign rd_value = rd_ok ? entries[pos_ext[IDX_W-1:0]] : '0;

    // result word
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (accept) begin
            m_valid_next            = 1'b1;
            m_data_next.read_value  = rd_value;
            m_data_next.status      = status_c;
            m_data_next.entry_count = ENTRY_W'(count_next);
            m_data_next.is_empty    = (count_next == '0);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ===== design/indexed_list_engine_core.sv =====
// ----------------------------------------------------------------------------
// indexed_list_engine_core: ordered list of signed 32-bit values
// Append, insert, remove, remove-last and read on a list held in a row of
// cells, one result word for every input word.
// ----------------------------------------------------------------------------
// The engine returns the result word for an accepted word in the cycle after
// acceptance, held in an output register. While that result waits for the
// sink the input is held off; a new word is taken in the same cycle as the
// waiting result leaves, so with the sink ready throughput is one word per
// cycle: every slot of the list is a cell that moves to or from its
// neighbour together with all the others, so an insert or remove shifts the
// whole list at once. No word is taken during reset. Entries are undefined
// after reset and are only ever read below the current count.
module indexed_list_engine_core
    import ile_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    cell_cmd_t cmd;
    data_t     entries [CAPACITY];

    ile_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .entries (entries),
        .cmd     (cmd)
    );

    // row of slots, each wired to both neighbours
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        data_t lower_w;
        data_t upper_w;

        if (i == 0) begin : g_head
            assign lower_w = '0;
        end else begin : g_lower
            assign lower_w = entries[i-1];
        end

        if (i == CAPACITY - 1) begin : g_tail
            assign upper_w = '0;
        end else begin : g_upper
            assign upper_w = entries[i+1];
        end

        ile_cell u_cell (
            .aclk     (aclk),
            .cmd      (cmd),
            .cell_idx (CMP_W'(i)),
            .lower    (lower_w),
            .upper    (upper_w),
            .value    (entries[i])
        );
    end

endmodule

// ===== design/ile_checker.sv =====
// ----------------------------------------------------------------------------
// ile_checker: port-level checks of the indexed list engine
// Watches the result channel for consistency of its fields and for a held
// word under back-pressure; bound to the top level.
// ----------------------------------------------------------------------------
module ile_checker
    import ile_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      m_valid,
    input logic      m_ready,
    input out_word_t m_data
);

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result word changed under back-pressure");

    // empty flag follows the count
    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.is_empty == (m_data.entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    // only a good read carries data
    a_read_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status != ST_OK) |-> (m_data.read_value == '0))
        else $error("read value set on a failed operation");

    // count never exceeds the list depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (CNT_W'(m_data.entry_count) <= CNT_W'(CAPACITY)))
        else $error("entry count beyond list depth");

    // a full status comes only from a full list
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.status == ST_FULL)
            |-> (CNT_W'(m_data.entry_count) == CNT_W'(CAPACITY)))
        else $error("full status with room left");

endmodule

bind indexed_list_engine_core ile_checker u_ile_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== tb/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the indexed list engine
// Drives opcode words into the engine, keeps its own copy of the list to
// work out the result word each one should give, and compares every result
// field by field in arrival order. Covers the empty and full boundaries,
// every opcode including the unused codes, and long random runs with
// random gaps and back-pressure on both channels.
// ----------------------------------------------------------------------------
module tb_top;

    import ile_pkg::*;

    localparam logic [OPC_W-1:0] OP_TOP  = '1;
    localparam int               POS_MAX = (1 << POS_W) - 1;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    // shadow copy of the list
    data_t list_mem [CAPACITY];
    int    list_len = 0;

    out_word_t results_due [$];

    bit src_gaps    = 1'b1;
    bit sink_stalls = 1'b1;
    int stall_left  = 0;
    int fill_target = CAPACITY / 2;
    int err_count   = 0;
    int n_sent      = 0;
    int n_checked   = 0;
    int n_full      = 0;
    int n_empty     = 0;
    int n_badpos    = 0;

    indexed_list_engine_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // clock
    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    // gap length: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 19);
        if (r < 10) return 0;
        if (r < 18) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic data_t pick_value();
        case ($urandom_range(0, 19))
            0: return data_t'(32'h8000_0000);
            1: return data_t'(32'h7fff_ffff);
            2: return '0;
            3: return '1;
            default: return data_t'($urandom());
        endcase
    endfunction

    function automatic in_word_t list_word(input logic [OPC_W-1:0] op,
                                           input int pos, input data_t val);
        in_word_t w;
        w.opcode     = op;
        w.position   = pos[POS_W-1:0];
        w.item_value = val;
        return w;
    endfunction

    // applies one word to the shadow list and returns the result it gives
    function automatic out_word_t apply_list_op(input in_word_t w);
        out_word_t r;
        int p;
        r        = '0;
        r.status = ST_OK;
        p        = int'(w.position);
        case (w.opcode)
            OP_APPEND: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    list_mem[IDX_W'(list_len)] = w.item_value;
                    list_len++;
                end
            end
            OP_INSERT: begin
                if (list_len >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (p > list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (int k = list_len; k > p; k--)
                        list_mem[IDX_W'(k)] = list_mem[IDX_W'(k-1)];
                    list_mem[IDX_W'(p)] = w.item_value;
                    list_len++;
                end
            end
            OP_REMOVE: begin
                if (list_len == 0) begin
                    r.status = ST_EMPTY;
                end else if (p >= list_len) begin
                    r.status = ST_BADPOS;
                end else begin
                    for (int k = p; k + 1 < list_len; k++)
                        list_mem[IDX_W'(k)] = list_mem[IDX_W'(k+1)];
                    list_len--;
                end
            end
            OP_REMOVE_END: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else list_len--;
            end
            OP_READ: begin
                if (list_len == 0) r.status = ST_EMPTY;
                else if (p >= list_len) r.status = ST_BADPOS;
                else r.read_value = list_mem[IDX_W'(p)];
            end
            default: r.status = ST_BADPOS;
        endcase
        r.entry_count = list_len[ENTRY_W-1:0];
        r.is_empty    = (list_len == 0);
        return r;
    endfunction

    // random word, steered so the count wanders towards fill_target
    function automatic in_word_t random_list_word();
        in_word_t w;
        int r, add_w, rem_w;
        w.item_value = pick_value();
        w.position   = POS_W'($urandom_range(0, POS_MAX));
        add_w = (list_len < fill_target) ? 55 : 15;
        rem_w = (list_len > fill_target) ? 50 : 15;
        r = $urandom_range(0, 99);
        if (r < 3)
            w.opcode = OPC_W'($urandom_range(OP_READ + 1, OP_TOP));
        else if (r < 3 + add_w)
            w.opcode = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
        else if (r < 3 + add_w + rem_w)
            w.opcode = ($urandom_range(0, 2) == 0) ? OP_REMOVE_END : OP_REMOVE;
        else
            w.opcode = OP_READ;
        // most positions land inside the list, the rest anywhere
        if ($urandom_range(0, 9) < 8) begin
            if (w.opcode == OP_INSERT)
                w.position = POS_W'($urandom_range(0, list_len));
            else if (list_len > 0)
                w.position = POS_W'($urandom_range(0, list_len - 1));
        end
        return w;
    endfunction

    // result side back-pressure
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if (sink_stalls && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            m_ready    <= 1'b0;
        end else begin
            m_ready    <= 1'b1;
        end
    end

    // result checker
    always @(posedge aclk) begin
        out_word_t want;
        if (aresetn && m_valid && m_ready) begin
            if (results_due.size() == 0) begin
                $error("result word with no expectation waiting");
                err_count++;
            end else begin
                want = results_due.pop_front();
                n_checked++;
                if (m_data.read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d",
                           want.read_value, m_data.read_value);
                    err_count++;
                end
                if (m_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_data.status);
                    err_count++;
                end
                if (m_data.entry_count !== want.entry_count) begin
                    $error("entry_count: expected %0d, got %0d",
                           want.entry_count, m_data.entry_count);
                    err_count++;
                end
                if (m_data.is_empty !== want.is_empty) begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, m_data.is_empty);
                    err_count++;
                end
            end
        end
    end

    // send one word, record its expected result on acceptance
    task automatic send_word(input in_word_t w);
        int gap;
        out_word_t want;
        gap = src_gaps ? pick_gap() : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (s_ready !== 1'b1);
        want = apply_list_op(w);
        results_due.push_back(want);
        n_sent++;
        case (want.status)
            ST_FULL:   n_full++;
            ST_EMPTY:  n_empty++;
            ST_BADPOS: n_badpos++;
            default: ;
        endcase
    endtask

    // hold off the sender until every result is back
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge aclk);
    endtask

    // empty list cases, unused codes, head/tail/middle edits, bad positions
    task automatic test_boundaries();
        send_word(list_word(OP_READ, 0, '0));
        send_word(list_word(OP_REMOVE, 0, '0));
        send_word(list_word(OP_REMOVE_END, 0, '0));
        send_word(list_word(OP_INSERT, 1, data_t'(32'h1234_5678)));
        for (int op = OP_READ + 1; op <= OP_TOP; op++)
            send_word(list_word(OPC_W'(op), POS_MAX, '1));
        send_word(list_word(OP_APPEND, POS_MAX, data_t'(32'h7fff_ffff)));
        send_word(list_word(OP_APPEND, 0, data_t'(32'h8000_0000)));
        send_word(list_word(OP_INSERT, 0, '0));
        send_word(list_word(OP_INSERT, 3, '1));
        send_word(list_word(OP_INSERT, 2, data_t'(32'h5a5a_5a5a)));
        send_word(list_word(OP_INSERT, POS_MAX, data_t'(32'ha5a5_a5a5)));
        send_word(list_word(OP_READ, 0, '0));
        send_word(list_word(OP_READ, 4, '0));
        send_word(list_word(OP_READ, 5, '0));
        send_word(list_word(OP_READ, POS_MAX, '0));
        send_word(list_word(OP_REMOVE, 0, '0));
        send_word(list_word(OP_REMOVE, 4, '0));
        send_word(list_word(OP_REMOVE, POS_MAX, '0));
        send_word(list_word(OP_REMOVE, 1, '0));
        send_word(list_word(OP_REMOVE_END, 0, '0));
        wait_drained();
    endtask

    // random mix with a moving fill level
    task automatic test_random_mix(input int n_words, input bit vary_idle);
        for (int i = 0; i < n_words; i++) begin
            if (i % 50 == 0) begin
                fill_target = $urandom_range(0, CAPACITY);
                if (vary_idle) begin
                    src_gaps    = ($urandom_range(0, 3) != 0);
                    sink_stalls = ($urandom_range(0, 3) != 0);
                end
            end
            if ($urandom_range(0, 149) == 0) wait_drained();
            send_word(random_list_word());
        end
        wait_drained();
    endtask

    // fill to capacity, poke the full list, drain, poke the empty list
    task automatic test_fill_drain(input int rounds);
        in_word_t w;
        repeat (rounds) begin
            while (list_len < CAPACITY) begin
                w.item_value = pick_value();
                if ($urandom_range(0, 1)) begin
                    w.opcode   = OP_APPEND;
                    w.position = POS_W'($urandom_range(0, POS_MAX));
                end else begin
                    w.opcode   = OP_INSERT;
                    w.position = POS_W'($urandom_range(0, list_len));
                end
                send_word(w);
            end
            repeat (4) begin
                w.item_value = pick_value();
                w.position   = POS_W'($urandom_range(0, POS_MAX));
                w.opcode     = $urandom_range(0, 1) ? OP_APPEND : OP_INSERT;
                if ($urandom_range(0, 2) == 0) w.opcode = OP_READ;
                send_word(w);
            end
            while (list_len > 0) begin
                w.item_value = pick_value();
                w.position   = POS_W'($urandom_range(0, list_len - 1));
                if ($urandom_range(0, 3) == 0) w.opcode = OP_READ;
                else w.opcode = $urandom_range(0, 1) ? OP_REMOVE : OP_REMOVE_END;
                send_word(w);
            end
            repeat (3) begin
                w.item_value = pick_value();
                w.position   = POS_W'($urandom_range(0, POS_MAX));
                if ($urandom_range(0, 3) == 0) begin
                    w.opcode   = OP_INSERT;
                    w.position = POS_W'($urandom_range(1, POS_MAX));
                end else if ($urandom_range(0, 2) == 0) begin
                    w.opcode = OP_REMOVE_END;
                end else begin
                    w.opcode = $urandom_range(0, 1) ? OP_REMOVE : OP_READ;
                end
                send_word(w);
            end
        end
        wait_drained();
    endtask

    // full rate on both channels
    task automatic test_back_to_back(input int n_words);
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        test_random_mix(n_words, 1'b0);
        src_gaps    = 1'b1;
        sink_stalls = 1'b1;
    endtask

    // test sequence
    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_boundaries();
        test_random_mix(1000, 1'b1);
        test_fill_drain(10);
        test_back_to_back(300);

        wait_drained();
        repeat (8) @(posedge aclk);

        $display("tb_top summary: %0d words sent, %0d results checked", n_sent, n_checked);
        $display("tb_top summary: %0d full, %0d empty and %0d bad position rejections",
                 n_full, n_empty, n_badpos);
        if (err_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // watchdog
    initial begin
        #12_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule
